[rtl/dbir_pkg.sv]
`default_nettype none

package dbir_pkg;

	// Register map, one 32-bit register every four bytes.
	localparam int unsigned PADDR_W = 5;
	localparam int unsigned REG_IDX_W = 3;

	localparam logic [REG_IDX_W-1:0] REG_CHANNEL_ACTIVE = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_INVERT_MODE    = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_DEBOUNCE_MS    = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_PERIODIC_MS    = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_QUERY_DELAY_MS = 3'd4;

	localparam logic [7:0] QUERY_DELAY_RESET = 8'd10;

	localparam logic CAUSE_CHANGE   = 1'b0;
	localparam logic CAUSE_PERIODIC = 1'b1;

	// Report queue: a tick can leave two reports behind.
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W      = 2;
	localparam int unsigned QCNT_W      = 3;

	typedef struct packed {
		logic report_value;
		logic report_cause;
		logic last_of_tick;
	} report_t;

endpackage

`default_nettype wire

[rtl/dbir_if.sv]
`default_nettype none

interface dbir_tick_if;
	logic valid;
	logic ready;
	logic pin_level;

	modport source (output valid, output pin_level, input ready);
	modport sink (input valid, input pin_level, output ready);
endinterface

interface dbir_report_if;
	logic valid;
	logic ready;
	logic report_value;
	logic report_cause;
	logic last_of_tick;

	modport source (output valid, output report_value, output report_cause,
		output last_of_tick, input ready);
	modport sink (input valid, input report_value, input report_cause,
		input last_of_tick, output ready);
endinterface

`default_nettype wire

[rtl/debounced_binary_input_reporter.sv]
`default_nettype none

// Debounced active-low contact input with change and periodic reports. Each tick
// transaction is one millisecond of local time carrying the raw pin level. A tick
// is taken into an input register and evaluated from there, so one tick per clock
// cycle is sustained while the report queue has room; a tick produces zero, one or
// two report transactions, which wait in a four-entry report queue and leave one per
// cycle while the receiver is ready. The rate is set by the queue: a tick is
// evaluated only while two queue entries are free, so a stalled report channel
// stalls the tick channel after at most two ticks' worth of reports. The user must
// write configuration over the APB port only while no tick is in flight; the block
// does not enforce this. TIME_BITS sets the width of the local millisecond clock.
module debounced_binary_input_reporter #(
	parameter int unsigned TIME_BITS = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	dbir_tick_if.sink                          tick,
	dbir_report_if.source                      report,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [dbir_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [31:0]                   pwdata,
	output logic      [31:0]                   prdata,
	output logic                               pready
);

	// Configuration registers
	logic        channel_active_q;
	logic        invert_mode_q;
	logic [7:0]  debounce_ms_q;
	logic [31:0] periodic_ms_q;
	logic [7:0]  query_delay_ms_q;

	logic                               cfg_wr;
	logic [dbir_pkg::REG_IDX_W-1:0]     cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = paddr[dbir_pkg::PADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_active_q <= 1'b0;
			invert_mode_q    <= 1'b0;
			debounce_ms_q    <= 8'd0;
			periodic_ms_q    <= 32'd0;
			query_delay_ms_q <= dbir_pkg::QUERY_DELAY_RESET;
		end else if (cfg_wr) begin
			case (cfg_idx)
				dbir_pkg::REG_CHANNEL_ACTIVE: channel_active_q <= pwdata[0];
				dbir_pkg::REG_INVERT_MODE:    invert_mode_q    <= pwdata[0];
				dbir_pkg::REG_DEBOUNCE_MS:    debounce_ms_q    <= pwdata[7:0];
				dbir_pkg::REG_PERIODIC_MS:    periodic_ms_q    <= pwdata;
				dbir_pkg::REG_QUERY_DELAY_MS: query_delay_ms_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			dbir_pkg::REG_CHANNEL_ACTIVE: prdata = {31'd0, channel_active_q};
			dbir_pkg::REG_INVERT_MODE:    prdata = {31'd0, invert_mode_q};
			dbir_pkg::REG_DEBOUNCE_MS:    prdata = {24'd0, debounce_ms_q};
			dbir_pkg::REG_PERIODIC_MS:    prdata = periodic_ms_q;
			dbir_pkg::REG_QUERY_DELAY_MS: prdata = {24'd0, query_delay_ms_q};
			default:                      prdata = 32'd0;
		endcase
	end

	// Input register
	logic valid_s1;
	logic pin_level_s1;
	logic proc;
	logic tick_acc;

	logic [dbir_pkg::QCNT_W-1:0] cnt_q;

	// Evaluate the registered tick only when two queue entries are free.
	assign proc       = valid_s1 && (cnt_q <= dbir_pkg::QCNT_W'(dbir_pkg::QUEUE_DEPTH - 2));
	assign tick.ready = !valid_s1 || proc;
	assign tick_acc   = tick.valid && tick.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick.ready) begin
			valid_s1 <= tick.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_acc) begin
			pin_level_s1 <= tick.pin_level;
		end
	end

	// Debounce state
	logic [TIME_BITS-1:0] now_ms_q;
	logic                 held_state_q;
	logic                 last_sample_q;
	logic [TIME_BITS-1:0] bounce_start_ms_q;
	logic [TIME_BITS-1:0] last_query_ms_q;
	logic [TIME_BITS-1:0] last_periodic_ms_q;

	logic [TIME_BITS-1:0] now_next;
	logic [TIME_BITS-1:0] query_el;
	logic [TIME_BITS-1:0] bounce_start_next;
	logic [TIME_BITS-1:0] bounce_el;
	logic [TIME_BITS-1:0] periodic_el;
	logic                 sample;
	logic                 do_query;
	logic                 do_change;
	logic                 do_periodic;
	logic                 held_next;
	logic                 rep_value;

	always_comb begin
		now_next          = now_ms_q + TIME_BITS'(1);
		sample            = ~pin_level_s1;
		query_el          = now_next - last_query_ms_q;
		do_query          = channel_active_q
			&& (query_el > TIME_BITS'(query_delay_ms_q));
		bounce_start_next = (sample != last_sample_q) ? now_next : bounce_start_ms_q;
		bounce_el         = now_next - bounce_start_next;
		do_change         = do_query && (bounce_el > TIME_BITS'(debounce_ms_q))
			&& (sample != held_state_q);
		held_next         = do_change ? sample : held_state_q;
		periodic_el       = now_next - last_periodic_ms_q;
		// The interval may be wider than the clock, so compare at 32 bits.
		do_periodic       = channel_active_q && (periodic_ms_q != 32'd0)
			&& (32'(periodic_el) > periodic_ms_q);
		rep_value         = held_next ^ invert_mode_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_ms_q           <= '0;
			held_state_q       <= 1'b0;
			last_sample_q      <= 1'b0;
			bounce_start_ms_q  <= '0;
			last_query_ms_q    <= '0;
			last_periodic_ms_q <= '0;
		end else if (proc) begin
			now_ms_q <= now_next;
			if (do_query) begin
				last_query_ms_q   <= now_next;
				last_sample_q     <= sample;
				bounce_start_ms_q <= bounce_start_next;
			end
			held_state_q <= held_next;
			if (do_periodic) begin
				last_periodic_ms_q <= now_next;
			end
		end
	end

	// Report queue
	dbir_pkg::report_t q_mem [dbir_pkg::QUEUE_DEPTH];
	logic [dbir_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [dbir_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [dbir_pkg::QPTR_W-1:0] wr_ptr_nx1;
	logic [1:0]                  push_n;
	logic                        pop;
	dbir_pkg::report_t           chg_rep;
	dbir_pkg::report_t           per_rep;
	dbir_pkg::report_t           first_rep;

	always_comb begin
		chg_rep.report_value = rep_value;
		chg_rep.report_cause = dbir_pkg::CAUSE_CHANGE;
		chg_rep.last_of_tick = !do_periodic;
		per_rep.report_value = rep_value;
		per_rep.report_cause = dbir_pkg::CAUSE_PERIODIC;
		per_rep.last_of_tick = 1'b1;
		first_rep            = do_change ? chg_rep : per_rep;
		push_n               = proc ? ({1'b0, do_change} + {1'b0, do_periodic}) : 2'd0;
		wr_ptr_nx1           = wr_ptr_q + dbir_pkg::QPTR_W'(1);
	end

	assign pop = report.valid && report.ready;

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			q_mem[wr_ptr_q] <= first_rep;
		end
		if (push_n == 2'd2) begin
			q_mem[wr_ptr_nx1] <= per_rep;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + dbir_pkg::QPTR_W'(push_n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + dbir_pkg::QPTR_W'(1);
			end
			cnt_q <= cnt_q + dbir_pkg::QCNT_W'(push_n) - dbir_pkg::QCNT_W'(pop);
		end
	end

	assign report.valid        = (cnt_q != '0);
	assign report.report_value = q_mem[rd_ptr_q].report_value;
	assign report.report_cause = q_mem[rd_ptr_q].report_cause;
	assign report.last_of_tick = q_mem[rd_ptr_q].last_of_tick;

	// Assertions
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= dbir_pkg::QCNT_W'(dbir_pkg::QUEUE_DEPTH))
		else $error("report queue overfilled");

	a_periodic_last: assert property (@(posedge clk) disable iff (!arst_n)
		report.valid && (report.report_cause == dbir_pkg::CAUSE_PERIODIC)
		|-> report.last_of_tick)
		else $error("periodic report not marked last of tick");

	a_inactive_silent: assert property (@(posedge clk) disable iff (!arst_n)
		proc && !channel_active_q |=> cnt_q <= $past(cnt_q))
		else $error("report produced while channel inactive");

	a_ptr_count: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0) || (cnt_q == dbir_pkg::QCNT_W'(dbir_pkg::QUEUE_DEPTH))
		|-> wr_ptr_q == rd_ptr_q)
		else $error("queue pointers disagree with fill count");

	a_hold_stage: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !proc |=> valid_s1 && $stable(pin_level_s1))
		else $error("stalled tick lost from input register");

endmodule

`default_nettype wire

[verif/dbir_report_checker.sv]
module dbir_report_checker #(
	parameter int unsigned TIME_BITS = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	dbir_tick_if                         tick,
	dbir_report_if                       report,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic                         pready,
	input  logic [dbir_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output int unsigned                  pending,
	output int unsigned                  fail_count
);
	timeunit 1ns;
	timeprecision 1ps;

	logic                 channel_active;
	logic                 invert_mode;
	logic [7:0]           debounce_ms;
	logic [31:0]          periodic_ms;
	logic [7:0]           query_delay_ms;

	logic [TIME_BITS-1:0] now_ms;
	logic [TIME_BITS-1:0] bounce_start_ms;
	logic [TIME_BITS-1:0] last_query_ms;
	logic [TIME_BITS-1:0] last_periodic_ms;
	logic                 held_state;
	logic                 last_level;

	dbir_pkg::report_t    expected_reports[$];
	dbir_pkg::report_t    want;

	// Differences stay at the clock width, so they wrap as the clock does.
	function automatic logic [TIME_BITS-1:0] elapsed(input logic [TIME_BITS-1:0] since);
		return now_ms - since;
	endfunction

	function automatic dbir_pkg::report_t make_report(input logic cause);
		dbir_pkg::report_t rep;
		rep.report_value = held_state ^ invert_mode;
		rep.report_cause = cause;
		rep.last_of_tick = 1'b0;
		return rep;
	endfunction

	task automatic report_mismatch(input string what);
		$display("%0t ns: %s", $time, what);
		fail_count++;
	endtask

	task automatic reset_debouncer();
		channel_active = 1'b0;
		invert_mode = 1'b0;
		debounce_ms = '0;
		periodic_ms = '0;
		query_delay_ms = dbir_pkg::QUERY_DELAY_RESET;
		now_ms = '0;
		bounce_start_ms = '0;
		last_query_ms = '0;
		last_periodic_ms = '0;
		held_state = 1'b0;
		last_level = 1'b0;
		expected_reports.delete();
	endtask

	task automatic write_register(input logic [dbir_pkg::REG_IDX_W-1:0] idx,
		input logic [31:0] data);
		case (idx)
			dbir_pkg::REG_CHANNEL_ACTIVE: channel_active = data[0];
			dbir_pkg::REG_INVERT_MODE: invert_mode = data[0];
			dbir_pkg::REG_DEBOUNCE_MS: debounce_ms = data[7:0];
			dbir_pkg::REG_PERIODIC_MS: periodic_ms = data;
			dbir_pkg::REG_QUERY_DELAY_MS: query_delay_ms = data[7:0];
			default: ;
		endcase
	endtask

	// One millisecond tick: advance the clock, sample and debounce the pin, and
	// queue the change and periodic reports that the tick causes.
	task automatic debounce_tick(input logic pin);
		dbir_pkg::report_t found[$];
		logic              asserted;
		now_ms = now_ms + TIME_BITS'(1);
		if (!channel_active)
			return;
		if (elapsed(last_query_ms) > TIME_BITS'(query_delay_ms)) begin
			asserted = ~pin;
			last_query_ms = now_ms;
			if (asserted != last_level) begin
				bounce_start_ms = now_ms;
				last_level = asserted;
			end
			if (elapsed(bounce_start_ms) > TIME_BITS'(debounce_ms)
				&& asserted != held_state) begin
				held_state = asserted;
				found.push_back(make_report(dbir_pkg::CAUSE_CHANGE));
			end
		end
		if (periodic_ms != 32'd0 && 32'(elapsed(last_periodic_ms)) > periodic_ms) begin
			last_periodic_ms = now_ms;
			found.push_back(make_report(dbir_pkg::CAUSE_PERIODIC));
		end
		if (found.size() != 0)
			found[found.size() - 1].last_of_tick = 1'b1;
		foreach (found[i])
			expected_reports.push_back(found[i]);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reset_debouncer();
			fail_count = 0;
		end else begin
			// Reports leaving now belong to earlier ticks, so compare before predicting.
			if (report.valid && report.ready) begin
				if (expected_reports.size() == 0) begin
					report_mismatch("report transaction with no expectation waiting");
				end else begin
					want = expected_reports.pop_front();
					if (report.report_value !== want.report_value)
						report_mismatch($sformatf("report_value %b, expected %b",
							report.report_value, want.report_value));
					if (report.report_cause !== want.report_cause)
						report_mismatch($sformatf("report_cause %b, expected %b",
							report.report_cause, want.report_cause));
					if (report.last_of_tick !== want.last_of_tick)
						report_mismatch($sformatf("last_of_tick %b, expected %b",
							report.last_of_tick, want.last_of_tick));
				end
			end
			if (psel && penable && pwrite && pready)
				write_register(paddr[dbir_pkg::PADDR_W-1:2], pwdata);
			if (tick.valid && tick.ready)
				debounce_tick(tick.pin_level);
		end
		pending = expected_reports.size();
	end

endmodule

[verif/tb_debounced_binary_input_reporter.sv]
module tb_debounced_binary_input_reporter;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CYCLE_LIMIT = 300000;
	localparam int unsigned HOLD_CYCLES = 400;
	localparam int unsigned SETTLE_CYCLES = 4;

	typedef enum logic [1:0] {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idle_mode_e;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         psel;
	logic                         penable;
	logic                         pwrite;
	logic [dbir_pkg::PADDR_W-1:0] paddr;
	logic [31:0]                  pwdata;
	logic [31:0]                  prdata;
	logic                         pready;

	int unsigned        pending;
	int unsigned        fail_count;
	int unsigned        cycles = 0;
	int unsigned        src_idle_pct = 0;
	int unsigned        snk_idle_pct = 0;
	int unsigned        hold_req = 0;
	int unsigned        hold_ack = 0;
	int unsigned        hold_left = 0;

	dbir_tick_if   tick_ch();
	dbir_report_if report_ch();

	debounced_binary_input_reporter #(
		.TIME_BITS(32)
	) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (tick_ch),
		.report (report_ch),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready)
	);

	dbir_report_checker #(
		.TIME_BITS(32)
	) u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.tick      (tick_ch),
		.report    (report_ch),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.pready    (pready),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.pending   (pending),
		.fail_count(fail_count)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Report receiver: a requested long hold-off takes priority over random stalls.
	always @(posedge clk) begin
		if (hold_ack != hold_req) begin
			hold_ack <= hold_req;
			hold_left <= HOLD_CYCLES;
			report_ch.ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			report_ch.ready <= 1'b0;
		end else begin
			report_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
		end
	end

	task automatic apb_write(input logic [dbir_pkg::REG_IDX_W-1:0] idx,
		input logic [31:0] data);
		logic done;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= dbir_pkg::PADDR_W'({idx, 2'b00});
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do begin
			@(negedge clk);
			done = pready;
			@(posedge clk);
		end while (!done);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	// Random junk fills the bits above the register's width.
	task automatic write_field(input logic [dbir_pkg::REG_IDX_W-1:0] idx,
		input logic [31:0] value, input logic [31:0] mask);
		apb_write(idx, ($urandom() & ~mask) | (value & mask));
	endtask

	task automatic configure(input logic act, input logic inv, input logic [7:0] deb,
		input logic [31:0] per, input logic [7:0] qd);
		write_field(dbir_pkg::REG_INVERT_MODE, 32'(inv), 32'h1);
		write_field(dbir_pkg::REG_DEBOUNCE_MS, 32'(deb), 32'hFF);
		write_field(dbir_pkg::REG_PERIODIC_MS, per, 32'hFFFF_FFFF);
		write_field(dbir_pkg::REG_QUERY_DELAY_MS, 32'(qd), 32'hFF);
		write_field(dbir_pkg::REG_CHANNEL_ACTIVE, 32'(act), 32'h1);
	endtask

	task automatic set_idle(input idle_mode_e mode);
		case (mode)
			IDLE_NONE: begin
				src_idle_pct = 0;
				snk_idle_pct <= 0;
			end
			IDLE_SENDER: begin
				src_idle_pct = 73;
				snk_idle_pct <= 0;
			end
			IDLE_RECEIVER: begin
				src_idle_pct = 0;
				snk_idle_pct <= 73;
			end
			default: begin
				src_idle_pct = 18;
				snk_idle_pct <= 18;
			end
		endcase
	endtask

	// Valid stays high from one tick to the next unless an idle cycle is taken.
	task automatic send_tick(input logic level);
		logic took;
		while (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
			tick_ch.valid <= 1'b0;
			@(posedge clk);
		end
		tick_ch.valid <= 1'b1;
		tick_ch.pin_level <= level;
		do begin
			@(negedge clk);
			took = tick_ch.ready;
			@(posedge clk);
		end while (!took);
	endtask

	// A tick that causes no report may still be in flight, hence the settling cycles.
	task automatic wait_idle();
		tick_ch.valid <= 1'b0;
		do
			@(negedge clk);
		while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Runs of steady pin level with the odd short glitch, so that samples get past
	// the debounce time as well as being thrown away.
	task automatic pin_runs(input int unsigned count, input int unsigned max_run,
		input bit pause_midway);
		int unsigned sent;
		int unsigned run_len;
		logic        level;
		sent = 0;
		while (sent < count) begin
			level = 1'($urandom_range(0, 1));
			run_len = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3)
				: $urandom_range(1, max_run);
			repeat (run_len) begin
				if (sent < count) begin
					send_tick(level);
					sent++;
					if (pause_midway && sent == count / 2)
						wait_idle();
				end
			end
		end
	endtask

	task automatic directed_part();
		// Straight after reset the channel is inactive: only the clock moves.
		send_tick(1'b0);
		send_tick(1'b1);
		send_tick(1'b0);
		wait_idle();
		apb_write(dbir_pkg::REG_CHANNEL_ACTIVE, 32'hFFFF_FFFE);
		send_tick(1'b0);
		wait_idle();
		apb_write(dbir_pkg::REG_QUERY_DELAY_MS, 32'hFFFF_FF00);
		apb_write(dbir_pkg::REG_DEBOUNCE_MS, 32'h0);
		apb_write(dbir_pkg::REG_INVERT_MODE, 32'h0);
		apb_write(dbir_pkg::REG_PERIODIC_MS, 32'h0);
		apb_write(dbir_pkg::REG_CHANNEL_ACTIVE, 32'hA5A5_A5A5);
		send_tick(1'b0);
		send_tick(1'b0);
		send_tick(1'b1);
		send_tick(1'b1);
		send_tick(1'b0);
		send_tick(1'b0);
		wait_idle();
		// Shortest period with inversion: change and periodic reports share ticks.
		apb_write(dbir_pkg::REG_INVERT_MODE, 32'h1);
		apb_write(dbir_pkg::REG_PERIODIC_MS, 32'h1);
		send_tick(1'b1);
		send_tick(1'b1);
		send_tick(1'b1);
		send_tick(1'b0);
		send_tick(1'b0);
		wait_idle();
		apb_write(dbir_pkg::REG_DEBOUNCE_MS, 32'hFFFF_FFFF);
		apb_write(dbir_pkg::REG_PERIODIC_MS, 32'hFFFF_FFFF);
		apb_write(dbir_pkg::REG_QUERY_DELAY_MS, 32'h0000_01FF);
		send_tick(1'b1);
		send_tick(1'b0);
		wait_idle();
	endtask

	initial begin
		int unsigned qd_choices[5] = '{0, 1, 2, 5, 10};
		int unsigned deb_choices[5] = '{0, 1, 3, 8, 20};
		int unsigned per_choices[6] = '{0, 0, 1, 3, 7, 40};
		int unsigned qd;
		int unsigned deb;
		logic [31:0] per;

		tick_ch.valid <= 1'b0;
		tick_ch.pin_level <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed_part();

		for (int p = 0; p < 10; p++) begin
			set_idle(idle_mode_e'(p % 4));
			case (p)
				0: begin
					// Reports on nearly every tick while the receiver holds off, so the
					// report queue fills and the tick channel backs up.
					configure(1'b1, 1'($urandom_range(0, 1)), 8'd0, 32'd1, 8'd0);
					hold_req <= hold_req + 1;
					pin_runs(150, 3, 1'b0);
				end
				1: begin
					configure(1'b1, 1'($urandom_range(0, 1)), 8'd0,
						32'($urandom_range(50, 120)), 8'd255);
					pin_runs(260, 700, 1'b0);
				end
				2: begin
					configure(1'b1, 1'($urandom_range(0, 1)), 8'd255, 32'd0, 8'd0);
					pin_runs(300, 400, 1'b0);
				end
				3: begin
					configure(1'b0, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 3)),
						32'($urandom_range(1, 4)), 8'($urandom_range(0, 3)));
					pin_runs(40, 10, 1'b0);
				end
				default: begin
					qd = qd_choices[$urandom_range(0, 4)];
					deb = deb_choices[$urandom_range(0, 4)];
					per = ($urandom_range(0, 6) == 6) ? $urandom()
						: per_choices[$urandom_range(0, 5)];
					configure(1'b1, 1'($urandom_range(0, 1)), 8'(deb), per, 8'(qd));
					pin_runs(60, 2 * (qd + 1) + deb + 10, p == 5);
				end
			endcase
			wait_idle();
		end

		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
